@@ rtl/fwle_pkg.sv @@
`default_nettype none

package fwle_pkg;

  // Sector space and dummy-block rotation
  localparam int unsigned SECTOR_TOTAL   = 256;
  localparam int unsigned POSITION_TOTAL = SECTOR_TOTAL + 1;
  localparam int unsigned MEM_DEPTH      = SECTOR_TOTAL + 1;

  localparam int unsigned SECTOR_W = 8;   // logical sector
  localparam int unsigned PHYS_W   = 9;   // physical sector, dummy included
  localparam int unsigned ROT_W    = 8;   // rotation count, below POSITION_TOTAL-1
  localparam int unsigned CNT_W    = 20;  // erase counter
  localparam int unsigned KEY_W    = 8;

  // Feistel split: B = bit length of SECTOR_TOTAL, low half rounded up
  localparam int unsigned FB_W = $clog2(SECTOR_TOTAL + 1);
  localparam int unsigned LO_W = (FB_W + 1) / 2;
  localparam int unsigned HI_W = FB_W - LO_W;

  localparam logic [CNT_W-1:0] CNT_MAX         = '1;
  localparam logic [CNT_W-1:0] ENDURANCE_RESET = CNT_W'(100000);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOMIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_THIRD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENDURANCE = 3'd4;

  typedef logic [KEY_W-1:0] key_set_t [3];

  typedef struct packed {
    logic                start;
    logic [SECTOR_W-1:0] sector;
  } perm_req_t;

  typedef struct packed {
    logic                done;
    logic [SECTOR_W-1:0] value;
  } perm_rsp_t;

endpackage

`default_nettype wire

@@ rtl/fwle_perm.sv @@
`default_nettype none

// Keyed Feistel permutation with cycle walking: one round per cycle,
// repeated in passes of three until the value falls inside the sector range.
module fwle_perm
  import fwle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire perm_req_t req,
  input  wire key_set_t  keys,
  output perm_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic [1:0]        round_r, round_nxt;
  logic [FB_W-1:0]   s_r, s_nxt;
  logic              done_r, done_nxt;

  logic [KEY_W-1:0]  key;
  logic [HI_W-1:0]   hi;
  logic [LO_W-1:0]   lo;
  logic [KEY_W-1:0]  t;
  logic [LO_W-1:0]   sq;
  logic [FB_W-1:0]   s_new;
  logic              in_range;

  always_comb begin
    unique case (round_r)
      2'd0:    key = keys[0];
      2'd1:    key = keys[1];
      default: key = keys[2];
    endcase
  end

  // only the low LO_W bits of the square feed the round
  always_comb begin
    hi       = s_r[FB_W-1 -: HI_W];
    lo       = s_r[LO_W-1:0];
    t        = KEY_W'(hi) ^ key;
    sq       = LO_W'(t * t);
    s_new    = {lo ^ sq, hi};
    in_range = ({1'b0, s_new} < (FB_W+1)'(SECTOR_TOTAL));
  end

  always_comb begin
    busy_nxt  = busy_r;
    round_nxt = round_r;
    s_nxt     = s_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      busy_nxt  = 1'b1;
      round_nxt = 2'd0;
      s_nxt     = FB_W'(req.sector);
    end else if (busy_r) begin
      s_nxt = s_new;
      if (round_r == 2'd2) begin
        round_nxt = 2'd0;
        if (in_range) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        round_nxt = round_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      round_r <= round_nxt;
      done_r  <= done_nxt;
    end
    s_r <= s_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = s_r[SECTOR_W-1:0];

endmodule

`default_nettype wire

@@ rtl/flash_wear_level_eraser_top.sv @@
`default_nettype none

// Flow: with permutation off, an accepted sector passes ST_ROT, ST_READ, ST_UPD;
// with it on, ST_PERM first runs the Feistel cycle walk (one round per cycle).
// Throughput: one transaction at a time; next accept the cycle after the result
// is loaded into the output register. Erase counters: 1 write and 1 read port.
// Reset (rst_n, synchronous) clears all control state, sets config defaults
// (limit 100000), then zeroes the 257 erase counters with in_stall held high.
module flash_wear_level_eraser_top
  import fwle_pkg::*;
#(
  parameter int unsigned UPDATE_INTERVAL = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SECTOR_W-1:0]  in_logical_sector,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PHYS_W-1:0]         out_physical_sector,
  output logic [CNT_W-1:0]          out_sector_erase_total,
  output logic                      out_worn_out,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  localparam int unsigned TALLY_W = (UPDATE_INTERVAL > 1) ? $clog2(UPDATE_INTERVAL) : 1;
  localparam logic [TALLY_W-1:0] TALLY_LAST = TALLY_W'(UPDATE_INTERVAL - 1);
  localparam logic [PHYS_W-1:0]  DUMMY_LAST = PHYS_W'(POSITION_TOTAL - 1);
  localparam logic [ROT_W-1:0]   ROT_LAST   = ROT_W'(POSITION_TOTAL - 2);
  localparam logic [PHYS_W-1:0]  CLR_LAST   = PHYS_W'(MEM_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PERM  = 6'b000100,
    ST_ROT   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_UPD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic             rand_en_r;
  key_set_t         keys_r;
  logic [CNT_W-1:0] limit_r;

  // wear-level counters
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic [PHYS_W-1:0]  dummy_r, dummy_nxt;
  logic [ROT_W-1:0]   rot_r, rot_nxt;
  logic [31:0]        cycles_r, cycles_nxt;

  logic [SECTOR_W-1:0] sector_r, sector_nxt;
  logic [PHYS_W-1:0]   phys_r, phys_nxt;
  logic [PHYS_W-1:0]   clr_r, clr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [PHYS_W-1:0]   out_phys_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_worn_r;

  // erase counter memory
  logic [CNT_W-1:0]  mem [MEM_DEPTH];
  logic [CNT_W-1:0]  mem_q;
  logic              mem_we;
  logic [PHYS_W-1:0] mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_re;

  perm_req_t perm_req;
  perm_rsp_t perm_rsp;

  logic             in_acc;
  logic             out_free;
  logic [PHYS_W:0]  diff;
  logic [PHYS_W-1:0] base;
  logic [CNT_W-1:0] cnt_inc;

  fwle_perm u_perm (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (perm_req),
    .keys (keys_r),
    .rsp  (perm_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign perm_req.start  = in_acc && rand_en_r;
  assign perm_req.sector = in_logical_sector;

  // (sector - rotation) mod SECTOR_TOTAL, then step over the dummy position
  always_comb begin
    diff = (PHYS_W+1)'(sector_r) + (PHYS_W+1)'(SECTOR_TOTAL) - (PHYS_W+1)'(rot_r);
    if (diff >= (PHYS_W+1)'(SECTOR_TOTAL)) begin
      diff = diff - (PHYS_W+1)'(SECTOR_TOTAL);
    end
    base = diff[PHYS_W-1:0];
  end

  assign cnt_inc = (mem_q == CNT_MAX) ? mem_q : mem_q + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    tally_nxt     = tally_r;
    dummy_nxt     = dummy_r;
    rot_nxt       = rot_r;
    cycles_nxt    = cycles_r;
    sector_nxt    = sector_r;
    phys_nxt      = phys_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = phys_r;
    mem_wdata     = cnt_inc;
    mem_re        = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + PHYS_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          sector_nxt = in_logical_sector;
          state_nxt  = rand_en_r ? ST_PERM : ST_ROT;
          if (tally_r == TALLY_LAST) begin
            tally_nxt = '0;
            if (dummy_r == DUMMY_LAST) begin
              dummy_nxt = '0;
              if (rot_r == ROT_LAST) begin
                rot_nxt    = '0;
                cycles_nxt = cycles_r + 32'd1;
              end else begin
                rot_nxt = rot_r + ROT_W'(1);
              end
            end else begin
              dummy_nxt = dummy_r + PHYS_W'(1);
            end
          end else begin
            tally_nxt = tally_r + TALLY_W'(1);
          end
        end
      end
      ST_PERM: begin
        if (perm_rsp.done) begin
          sector_nxt = perm_rsp.value;
          state_nxt  = ST_ROT;
        end
      end
      ST_ROT: begin
        phys_nxt  = (base >= dummy_r) ? base + PHYS_W'(1) : base;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      tally_r     <= '0;
      dummy_r     <= '0;
      rot_r       <= '0;
      cycles_r    <= '0;
      out_valid_r <= 1'b0;
      rand_en_r   <= 1'b0;
      keys_r[0]   <= '0;
      keys_r[1]   <= '0;
      keys_r[2]   <= '0;
      limit_r     <= ENDURANCE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tally_r     <= tally_nxt;
      dummy_r     <= dummy_nxt;
      rot_r       <= rot_nxt;
      cycles_r    <= cycles_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_RANDOMIZE:  rand_en_r <= cfg_data[0];
          REG_KEY_FIRST:  keys_r[0] <= cfg_data[KEY_W-1:0];
          REG_KEY_SECOND: keys_r[1] <= cfg_data[KEY_W-1:0];
          REG_KEY_THIRD:  keys_r[2] <= cfg_data[KEY_W-1:0];
          REG_ENDURANCE:  limit_r   <= cfg_data;
          default: ;
        endcase
      end
    end
    sector_r <= sector_nxt;
    phys_r   <= phys_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && out_free) begin
      out_phys_r <= phys_r;
      out_cnt_r  <= cnt_inc;
      out_worn_r <= (cnt_inc >= limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[phys_r];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_physical_sector    = out_phys_r;
  assign out_sector_erase_total = out_cnt_r;
  assign out_worn_out           = out_worn_r;

endmodule

`default_nettype wire
